>>> hw/rtl/slcr_pkg.sv
`timescale 1ns / 1ps

package slcr_pkg;

  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    logic en;
    op_e  op;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/slcr_cell.sv
`timescale 1ns / 1ps

module slcr_cell #(
  parameter int unsigned VW = 16
) (
  input  logic                clk_i,
  input  slcr_pkg::cell_ctrl_t ctrl_i,
  input  logic [VW-1:0]       req_val_i,
  input  logic                occ_i,
  input  logic [VW-1:0]       prev_val_i,
  input  logic                prev_hit_i,
  input  logic [VW-1:0]       next_val_i,
  output logic [VW-1:0]       val_o,
  output logic                hit_o
);

  logic [VW-1:0] val_q, val_d;
  logic          ins_hit, rem_hit;

  // insert: slot at or above the insert position
  assign ins_hit = !occ_i || (val_q > req_val_i);
  // remove: slot at or above the first fitting entry
  assign rem_hit = occ_i && (val_q >= req_val_i);

  always_comb begin
    unique case (ctrl_i.op)
      slcr_pkg::OP_INSERT: hit_o = ins_hit;
      slcr_pkg::OP_REMOVE: hit_o = rem_hit;
      default:             hit_o = 1'b0;
    endcase
  end

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      slcr_pkg::OP_INSERT: begin
        if (prev_hit_i) begin
          val_d = prev_val_i;
        end else if (ins_hit) begin
          val_d = req_val_i;
        end
      end
      slcr_pkg::OP_REMOVE: begin
        if (rem_hit) begin
          val_d = next_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> hw/rtl/sorted_list_ceiling_remove_core.sv
`timescale 1ns / 1ps

// Sorted multiset of up to CAPACITY unsigned values, kept in a row of
// compare-and-shift cells.
// Requests: drive req_type_i (0 insert, 1 remove smallest value >= value_i)
// and value_i with start_i high; the request is taken at a rising edge where
// start_i is high and busy_o is low. Only the low VALUE_WIDTH bits of value_i
// are used.
// Each request gives exactly one result: done_o is high for one cycle with
// ok_o (1 = inserted or removed, 0 = full or no fitting entry) and count_o,
// the number of stored values after the request.
// Sequence: a taken request moves the control from ST_IDLE to ST_EXEC, in which
// busy_o is high and the cells compare and shift; on leaving ST_EXEC the block
// registers done_o, ok_o and count_o, so a new request is taken only once the
// one before it has been through ST_EXEC.
// The receiver cannot stall: done_o lasts one cycle and is not held.
// Reset (rst_ni low, asynchronous) empties the list and clears busy_o and
// done_o; cell contents are not cleared, only slots below the count are read.
module sorted_list_ceiling_remove_core #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [15:0]                  value_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [slcr_pkg::COUNT_W-1:0] count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [CW-1:0] fill_q;
  logic          done_q, ok_q;
  logic [slcr_pkg::COUNT_W-1:0] count_q;

  slcr_pkg::op_e        op_q;
  logic [VALUE_WIDTH-1:0] req_val_q;

  logic [VALUE_WIDTH+15:0] value_ext;
  logic [VALUE_WIDTH-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0]     hit, occ;
  logic                    full, found, exec_ok;
  logic [CW-1:0]           fill_d;
  logic [CW+slcr_pkg::COUNT_W-1:0] fill_ext;
  slcr_pkg::cell_ctrl_t    ctrl;

  assign busy_o    = (state_q != ST_IDLE);
  assign value_ext = {{VALUE_WIDTH{1'b0}}, value_i};

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q      <= slcr_pkg::op_e'(req_type_i);
      req_val_q <= value_ext[VALUE_WIDTH-1:0];
    end
  end

  assign full  = (fill_q == CW'(CAPACITY));
  assign found = |hit;

  always_comb begin
    unique case (op_q)
      slcr_pkg::OP_INSERT: exec_ok = !full;
      slcr_pkg::OP_REMOVE: exec_ok = found;
      default:             exec_ok = 1'b0;
    endcase
  end

  assign ctrl.en = (state_q == ST_EXEC) && exec_ok;
  assign ctrl.op = op_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_val, next_val;
    logic                   prev_hit;

    assign occ[i] = (fill_q > CW'(i));

    if (i == 0) begin : g_first
      assign prev_val = cell_val[i];
      assign prev_hit = 1'b0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign prev_hit = hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_body
      assign next_val = cell_val[i+1];
    end

    slcr_cell #(
      .VW(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .req_val_i  (req_val_q),
      .occ_i      (occ[i]),
      .prev_val_i (prev_val),
      .prev_hit_i (prev_hit),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .hit_o      (hit[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (exec_ok) begin
      unique case (op_q)
        slcr_pkg::OP_INSERT: fill_d = fill_q + CW'(1);
        slcr_pkg::OP_REMOVE: fill_d = fill_q - CW'(1);
        default:             fill_d = fill_q;
      endcase
    end
  end

  assign fill_ext = {{slcr_pkg::COUNT_W{1'b0}}, fill_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          fill_q  <= fill_d;
          done_q  <= 1'b1;
          ok_q    <= exec_ok;
          count_q <= fill_ext[slcr_pkg::COUNT_W-1:0];
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign ok_o    = ok_q;
  assign count_o = count_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CAP = 16;
  localparam int unsigned RANDOM_REQS = 800;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    bit                           ok;
    bit [slcr_pkg::COUNT_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    slcr_pkg::op_e              op;
    bit [15:0]                  value;
    bit                         typed;
    bit                         ok;
    bit [slcr_pkg::COUNT_W-1:0] count;
  } req_row_t;

  // typed rows: known outcome, others come from the sorted-list predictor
  localparam req_row_t DIRECTED [25] = '{
    '{slcr_pkg::OP_REMOVE, 16'h0000, 1'b1, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h0000, 1'b1, 1'b1, 5'd1},
    '{slcr_pkg::OP_INSERT, 16'hffff, 1'b1, 1'b1, 5'd2},
    '{slcr_pkg::OP_REMOVE, 16'hffff, 1'b1, 1'b1, 5'd1},
    '{slcr_pkg::OP_REMOVE, 16'h0001, 1'b1, 1'b0, 5'd1},
    '{slcr_pkg::OP_REMOVE, 16'h0000, 1'b1, 1'b1, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd100,  1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd5,    1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd5,    1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'hffff, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h0000, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h7fff, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'haaaa, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h5555, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd200,  1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd5,    1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd1,    1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'hfffe, 1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd300,  1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd300,  1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'd50,   1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_INSERT, 16'h1234, 1'b1, 1'b0, 5'd16},
    '{slcr_pkg::OP_REMOVE, 16'd301,  1'b0, 1'b0, 5'd0},
    '{slcr_pkg::OP_REMOVE, 16'h0000, 1'b0, 1'b0, 5'd0}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic                         req_type_i = 1'b0;
  logic [15:0]                  value_i = '0;
  logic                         busy_o;
  logic                         done_o;
  logic                         ok_o;
  logic [slcr_pkg::COUNT_W-1:0] count_o;

  logic [15:0] sorted_values [$];
  outcome_t    pending_outcomes [$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet_run = 1'b0;

  sorted_list_ceiling_remove_core #(
    .CAPACITY   (CAP),
    .VALUE_WIDTH(16)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_type_i(req_type_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .ok_o      (ok_o),
    .count_o   (count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic outcome_t apply_to_list(input slcr_pkg::op_e op,
                                             input logic [15:0] v);
    outcome_t res;
    int       pos;
    res.ok = 1'b0;
    pos = 0;
    if (op == slcr_pkg::OP_INSERT) begin
      if (sorted_values.size() < CAP) begin
        while (pos < sorted_values.size() && sorted_values[pos] <= v) pos++;
        sorted_values.insert(pos, v);
        res.ok = 1'b1;
      end
    end else begin
      while (pos < sorted_values.size() && sorted_values[pos] < v) pos++;
      if (pos < sorted_values.size()) begin
        sorted_values.delete(pos);
        res.ok = 1'b1;
      end
    end
    res.count = slcr_pkg::COUNT_W'(sorted_values.size());
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom);
      4, 5, 6:    v = 16'($urandom_range(0, 15));
      7:          v = 16'hffff - 16'($urandom_range(0, 3));
      8:          v = 16'($urandom_range(0, 3));
      default: begin
        if (sorted_values.size() == 0) v = 16'($urandom);
        else v = sorted_values[$urandom_range(0, sorted_values.size() - 1)]
                 + 16'($urandom_range(0, 2)) - 16'd1;
      end
    endcase
    return v;
  endfunction

  task automatic issue(input slcr_pkg::op_e op, input logic [15:0] v, input int gap,
                       input bit typed, input bit t_ok,
                       input bit [slcr_pkg::COUNT_W-1:0] t_count);
    outcome_t res;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= op;
    value_i    <= v;
    do @(posedge clk_i); while (busy_o);
    res = apply_to_list(op, v);
    if (typed) begin
      res.ok    = t_ok;
      res.count = t_count;
    end
    pending_outcomes.push_back(res);
  endtask

  initial begin
    int insert_pct;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      issue(DIRECTED[i].op, DIRECTED[i].value, pick_gap(), DIRECTED[i].typed,
            DIRECTED[i].ok, DIRECTED[i].count);

    insert_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
        quiet_run = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_REQS / 2) begin
        // let the block drain completely
        start_i <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk_i);
      end
      issue(($urandom_range(0, 99) < insert_pct) ? slcr_pkg::OP_INSERT : slcr_pkg::OP_REMOVE,
            pick_value(), pick_gap(), 1'b0, 1'b0, '0);
    end

    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: ok %0d count %0d", ok_o, count_o);
        err_cnt++;
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (ok_o !== exp_res.ok) begin
          $error("ok: expected %0d, actual %0d", exp_res.ok, ok_o);
          err_cnt++;
        end
        if (count_o !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, count_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
